FILE: rtl/sds_pkg.sv
// Package for the sprite depth sort unit: entry and cell control types,
// state encoding, field widths, saturation and floor helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sds_pkg;

    localparam int IDX_W  = 6;
    localparam int VAL_W  = 32;
    localparam int PROD_W = 64;
    localparam int FLR_W  = 48;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [2:0] {
        CFG_VIEWER_X  = 3'd0,
        CFG_VIEWER_Y  = 3'd1,
        CFG_FACING_X  = 3'd2,
        CFG_FACING_Y  = 3'd3,
        CFG_PLANE_X   = 3'd4,
        CFG_PLANE_Y   = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] lat;
        logic signed [VAL_W-1:0] dep;
    } t_entry;

    typedef enum logic [1:0] {
        CELL_HOLD      = 2'd0,
        CELL_TAKE_NEW  = 2'd1,
        CELL_TAKE_PREV = 2'd2,
        CELL_TAKE_NEXT = 2'd3
    } t_cell_mode;

    typedef enum logic [4:0] {
        ST_IDLE, ST_D0, ST_D1, ST_D2, ST_DIVS, ST_DIV,
        ST_REL, ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6,
        ST_INS, ST_EMIT
    } t_state;

    // Clamp a 49-bit signed value to the 32-bit signed range.
    function automatic logic signed [VAL_W-1:0] sat49(input logic signed [48:0] v);
        logic hi_zero;
        logic hi_ones;
        begin
            hi_zero = ~|v[48:31];
            hi_ones = &v[48:31];
            if (hi_zero || hi_ones) begin
                sat49 = v[31:0];
            end else if (v[48]) begin
                sat49 = {1'b1, {(VAL_W-1){1'b0}}};
            end else begin
                sat49 = {1'b0, {(VAL_W-1){1'b1}}};
            end
        end
    endfunction

    // floor(p / 2^16) of a signed 64-bit product.
    function automatic logic signed [FLR_W-1:0] floor_q16(input logic signed [PROD_W-1:0] p);
        floor_q16 = p[PROD_W-1:16];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/sds_cell.sv
// One cell of the sorted entity chain: holds a single entry and loads it
// from the new entity or from either neighbor. Depends on sds_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sds_cell
    import sds_pkg::*;
(
    input  wire             i_clk,
    input  wire t_cell_mode i_mode,
    input  wire t_entry     i_new,
    input  wire t_entry     i_prev,
    input  wire t_entry     i_next,
    output t_entry          o_entry,
    output logic            o_ge
);

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        unique case (i_mode)
            CELL_HOLD:      n_entry = r_entry;
            CELL_TAKE_NEW:  n_entry = i_new;
            CELL_TAKE_PREV: n_entry = i_prev;
            CELL_TAKE_NEXT: n_entry = i_next;
            default:        n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    // Stored entity stays ahead of the new one on equal or greater depth.
    assign o_ge    = (r_entry.dep >= i_new.dep);
    assign o_entry = r_entry;

endmodule
`default_nettype wire

FILE: rtl/sds_div.sv
// Restoring divider that forms 2^32 / den one quotient bit per cycle.
// Depends on sds_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sds_div
    import sds_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire  [VAL_W-1:0]  i_den,
    output logic              o_done,
    output logic [VAL_W:0]    o_quo
);

    logic [VAL_W:0]   r_rem;
    logic [VAL_W:0]   r_quo;
    logic [VAL_W-1:0] r_den;
    logic [5:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [VAL_W:0]   w_sh;
    logic             w_fit;

    // The dividend is a single one followed by 32 zeros.
    assign w_sh  = {r_rem[VAL_W-1:0], (r_cnt == 6'(VAL_W))};
    assign w_fit = (w_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 6'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= '0;
            r_den <= i_den;
            r_cnt <= 6'(VAL_W);
        end else if (r_busy) begin
            r_rem <= w_fit ? (w_sh - {1'b0, r_den}) : w_sh;
            r_quo <= {r_quo[VAL_W-1:0], w_fit};
            r_cnt <= r_cnt - 6'd1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
`default_nettype wire

FILE: rtl/sprite_depth_sort_unit.sv
// Sprite depth sort unit: camera transform with a shared multiplier, a
// divider for the inverse determinant and a chain of sort cells.
// Depends on sds_pkg, sds_cell and sds_div.
//
// Usage: configuration writes on the cfg channel (index 0..5, data signed
// Q16.16) are always taken. After a write, or after reset, the block
// recomputes the inverse determinant, and s_axis_tready stays low while
// it does. Each entity item (x in tdata[31:0], y in tdata[63:32], tlast
// marks the end of the frame) then goes through a relative-position step,
// six passes through the one 32x32 multiplier and an insertion step into
// the cell chain, which keeps entries in depth order, farthest first; the
// next item is not taken before that insertion. After the tlast item the
// chain shifts out one entity per accepted output item, so a frame of n
// entities drains as n output items; tlast marks the last one. A stalled
// receiver simply holds the chain; no input is taken until the frame has
// drained. Entities beyond MAX_ENTITIES are dropped. Reset restores the
// default camera and empties the chain.
`timescale 1ns / 1ps
`default_nettype none
module sprite_depth_sort_unit
    import sds_pkg::*;
#(
    parameter int MAX_ENTITIES = 16
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire  [63:0]             s_axis_tdata,  // entity_x[31:0], entity_y[63:32]
    input  wire                     s_axis_tlast,  // final_entity
    output logic                    m_axis_tvalid,
    input  wire                     m_axis_tready,
    // entity_index[5:0], camera_x[37:6], camera_depth[69:38], zero pad
    output logic [71:0]             m_axis_tdata,
    output logic                    m_axis_tuser,  // degenerate
    output logic                    m_axis_tlast,  // final_result
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [VAL_W-1:0]        i_cfg_data
);

    localparam int CW = $clog2(MAX_ENTITIES + 1);

    t_state r_state;
    t_state n_state;

    logic signed [VAL_W-1:0] r_vx, r_vy, r_fx, r_fy, r_px, r_py;
    logic signed [VAL_W-1:0] r_inv, r_det;
    logic                    r_stale;
    logic [CW-1:0]           r_count;

    logic signed [VAL_W-1:0] r_ex, r_ey, r_rx, r_ry;
    logic                    r_last;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [FLR_W-1:0]  r_a;
    logic signed [VAL_W-1:0] r_lat_sum, r_dep_sum, r_lat, r_dep;

    logic signed [VAL_W-1:0] w_ma, w_mb;
    logic signed [FLR_W-1:0] w_flr;
    logic signed [48:0]      w_diff;
    logic signed [48:0]      w_scaled;
    logic                    w_in_acc, w_out_acc;
    logic                    w_div_start, w_div_done;
    logic [VAL_W:0]          w_quo;
    logic [VAL_W-1:0]        w_den_mag;
    logic signed [VAL_W+1:0] w_quo_s;

    t_entry     w_new;
    t_entry     w_ent  [MAX_ENTITIES];
    logic       w_ge   [MAX_ENTITIES];
    logic       w_keep [MAX_ENTITIES];
    t_cell_mode w_mode [MAX_ENTITIES];

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;
    assign w_flr     = floor_q16(r_prod);
    assign w_diff    = {r_a[FLR_W-1], r_a} - {w_flr[FLR_W-1], w_flr};
    assign w_scaled  = {w_flr[FLR_W-1], w_flr};

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (r_stale) begin
                    n_state = ST_D0;
                end else if (w_in_acc) begin
                    n_state = ST_REL;
                end
            end
            ST_D0:   n_state = ST_D1;
            ST_D1:   n_state = ST_D2;
            ST_D2:   n_state = ST_DIVS;
            ST_DIVS: n_state = (r_det == '0) ? ST_IDLE : ST_DIV;
            ST_DIV:  n_state = w_div_done ? ST_IDLE : ST_DIV;
            ST_REL:  n_state = ST_P0;
            ST_P0:   n_state = ST_P1;
            ST_P1:   n_state = ST_P2;
            ST_P2:   n_state = ST_P3;
            ST_P3:   n_state = ST_P4;
            ST_P4:   n_state = ST_P5;
            ST_P5:   n_state = ST_P6;
            ST_P6:   n_state = ST_INS;
            ST_INS:  n_state = r_last ? ST_EMIT : ST_IDLE;
            ST_EMIT: begin
                if (w_out_acc && r_count == CW'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and datapath controls
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE) && !r_stale;
        m_axis_tvalid = (r_state == ST_EMIT);
        o_cfg_ready   = 1'b1;
        w_div_start   = (r_state == ST_DIVS) && (r_det != '0);
        unique case (r_state)
            ST_D0:   begin w_ma = r_px;  w_mb = r_fy;      end
            ST_D1:   begin w_ma = r_py;  w_mb = r_fx;      end
            ST_P0:   begin w_ma = r_fy;  w_mb = r_rx;      end
            ST_P1:   begin w_ma = r_fx;  w_mb = r_ry;      end
            ST_P2:   begin w_ma = r_px;  w_mb = r_ry;      end
            ST_P3:   begin w_ma = r_py;  w_mb = r_rx;      end
            ST_P4:   begin w_ma = r_inv; w_mb = r_lat_sum; end
            ST_P5:   begin w_ma = r_inv; w_mb = r_dep_sum; end
            default: begin w_ma = '0;    w_mb = '0;        end
        endcase
    end

    assign w_den_mag = r_det[VAL_W-1] ? (~r_det + VAL_W'(1)) : r_det;
    assign w_quo_s   = r_det[VAL_W-1] ? -$signed({1'b0, w_quo}) : $signed({1'b0, w_quo});

    sds_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_den   (w_den_mag),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_vx    <= '0;
            r_vy    <= '0;
            r_fx    <= 32'sd65536;
            r_fy    <= '0;
            r_px    <= '0;
            r_py    <= 32'sd43254;
            r_inv   <= '0;
            r_stale <= 1'b1;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE && r_stale) begin
                r_stale <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_stale <= 1'b1;
                unique case (i_cfg_index)
                    CFG_VIEWER_X: r_vx <= i_cfg_data;
                    CFG_VIEWER_Y: r_vy <= i_cfg_data;
                    CFG_FACING_X: r_fx <= i_cfg_data;
                    CFG_FACING_Y: r_fy <= i_cfg_data;
                    CFG_PLANE_X:  r_px <= i_cfg_data;
                    CFG_PLANE_Y:  r_py <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == ST_DIVS && r_det == '0) begin
                r_inv <= '0;
            end else if (r_state == ST_DIV && w_div_done) begin
                r_inv <= sat49(49'(w_quo_s));
            end
            if (r_state == ST_INS && r_count != CW'(MAX_ENTITIES)) begin
                r_count <= r_count + CW'(1);
            end else if (w_out_acc) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Arithmetic pipeline registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        if (w_in_acc) begin
            r_ex   <= s_axis_tdata[31:0];
            r_ey   <= s_axis_tdata[63:32];
            r_last <= s_axis_tlast;
        end
        unique case (r_state)
            ST_D1, ST_P1, ST_P3: r_a <= floor_q16(r_prod);
            ST_D2: r_det     <= sat49(w_diff);
            ST_REL: begin
                r_rx <= sat49(49'($signed({r_ex[VAL_W-1], r_ex} - {r_vx[VAL_W-1], r_vx})));
                r_ry <= sat49(49'($signed({r_ey[VAL_W-1], r_ey} - {r_vy[VAL_W-1], r_vy})));
            end
            ST_P2: r_lat_sum <= sat49(w_diff);
            ST_P4: r_dep_sum <= sat49(w_diff);
            ST_P5: r_lat     <= sat49(w_scaled);
            ST_P6: r_dep     <= sat49(w_scaled);
            default: ;
        endcase
    end

    assign w_new.idx = IDX_W'(r_count);
    assign w_new.lat = r_lat;
    assign w_new.dep = r_dep;

    // Insertion: cells in front of the new entity hold, the first cell
    // behind them takes it, and the rest shift back by one.
    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTITIES; gi++) begin : g_chain
            assign w_keep[gi] = (CW'(gi) < r_count) && w_ge[gi];
            always_comb begin
                if (r_state == ST_INS && r_count != CW'(MAX_ENTITIES)) begin
                    if (w_keep[gi]) begin
                        w_mode[gi] = CELL_HOLD;
                    end else if (gi == 0) begin
                        w_mode[gi] = CELL_TAKE_NEW;
                    end else if (w_keep[(gi == 0) ? 0 : gi-1]) begin
                        w_mode[gi] = CELL_TAKE_NEW;
                    end else begin
                        w_mode[gi] = CELL_TAKE_PREV;
                    end
                end else if (w_out_acc) begin
                    w_mode[gi] = CELL_TAKE_NEXT;
                end else begin
                    w_mode[gi] = CELL_HOLD;
                end
            end
            sds_cell u_cell (
                .i_clk   (i_clk),
                .i_mode  (w_mode[gi]),
                .i_new   (w_new),
                .i_prev  (w_ent[(gi == 0) ? 0 : gi-1]),
                .i_next  (w_ent[(gi == MAX_ENTITIES-1) ? gi : gi+1]),
                .o_entry (w_ent[gi]),
                .o_ge    (w_ge[gi])
            );
        end
    endgenerate

    assign m_axis_tdata = {2'b00, w_ent[0].dep, w_ent[0].lat, w_ent[0].idx};
    assign m_axis_tuser = (r_inv == '0);
    assign m_axis_tlast = (r_count == CW'(1));

endmodule
`default_nettype wire

FILE: rtl/sds_checker.sv
// Port-level checks for the sprite depth sort unit, bound to its top level.
// Depends on sds_pkg and sprite_depth_sort_unit.
`timescale 1ns / 1ps
`default_nettype none
module sds_checker
    import sds_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        s_axis_tlast,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [71:0] m_axis_tdata,
    input wire        m_axis_tuser,
    input wire        m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a frame drains");

    a_last_in_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input ready right after a final item");

    a_last_out_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
        else $error("output continued past the final item");

    a_degen_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> $stable(m_axis_tuser))
        else $error("degenerate flag changed within a frame");

endmodule

bind sprite_depth_sort_unit sds_checker u_sds_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
